// ===== sv/slfm_pkg.sv =====
`timescale 1ns / 1ps

package slfm_pkg;

    localparam int COUNT_LIMIT = 31;
    localparam int COUNT_W     = $clog2(COUNT_LIMIT + 1);
    localparam int FLEN_W      = 5;
    localparam int CD_W        = 9;

    localparam logic [CD_W-1:0] CD_STOPPED = {CD_W{1'b1}};

    localparam logic [7:0] CHECK_INIT = 8'hFF;
    localparam logic [7:0] BYTE_ACK   = 8'h41;
    localparam logic [7:0] BYTE_POLL0 = 8'hC0;
    localparam logic [7:0] BYTE_POLL1 = 8'h00;
    localparam logic [7:0] BYTE_POLL2 = 8'h01;
    localparam logic [3:0] LEN_BASE   = 4'd3;

    localparam logic [7:0] TIMEOUT_RESET = 8'd5;

    // Configuration register indexes.
    localparam logic REG_MASTER_MODE   = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    typedef enum logic [1:0] {
        EV_TICK = 2'd0,
        EV_CPU  = 2'd1,
        EV_DEV  = 2'd2,
        EV_IRQ  = 2'd3
    } ev_kind_t;

    typedef enum logic [1:0] {
        FE_NONE = 2'd0,
        FE_ACK  = 2'd1,
        FE_GOOD = 2'd2,
        FE_BAD  = 2'd3
    } frame_event_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_SENT_C0 = 4'b0010,
        PH_SENT_00 = 4'b0100,
        PH_SENT_01 = 4'b1000
    } phase_t;

    localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_CODE_C0   = 2'd1;
    localparam logic [1:0] PHASE_CODE_00   = 2'd2;
    localparam logic [1:0] PHASE_CODE_01   = 2'd3;

    // Deframing state of one link direction.
    typedef struct packed {
        logic               start_pending;
        logic [COUNT_W-1:0] count;
        logic [7:0]         check;
        logic [7:0]         hdr0;
        logic [7:0]         hdr1;
    } dir_state_t;

    typedef struct packed {
        logic              send_valid;
        logic [7:0]        send_byte;
        frame_event_t      frame_event;
        logic              frame_from_device;
        logic [FLEN_W-1:0] frame_length;
        logic              replay_request;
        logic [1:0]        current_phase;
        logic              interrupt_pending;
    } result_t;

endpackage

// ===== sv/slfm_deframer.sv =====
`timescale 1ns / 1ps

module slfm_deframer
(
    input  slfm_pkg::dir_state_t   cur,
    input  logic [7:0]             byte_in,
    output slfm_pkg::dir_state_t   nxt,
    output slfm_pkg::frame_event_t frame_event
);

    logic [slfm_pkg::COUNT_W-1:0] old_cnt;
    logic [slfm_pkg::COUNT_W-1:0] new_cnt;
    logic [slfm_pkg::COUNT_W-1:0] end_len;
    logic [7:0]                   old_chk;
    logic [7:0]                   mixed;
    logic [7:0]                   new_chk;
    logic [7:0]                   h0;
    logic [7:0]                   h1;
    logic                         is_ack;
    logic                         is_len_end;

    // A pending start restarts the frame before this byte is counted.
    assign old_cnt = cur.start_pending ? '0 : cur.count;
    assign old_chk = cur.start_pending ? slfm_pkg::CHECK_INIT : cur.check;

    assign h0 = (old_cnt == slfm_pkg::COUNT_W'(0)) ? byte_in : cur.hdr0;
    assign h1 = (old_cnt == slfm_pkg::COUNT_W'(1)) ? byte_in : cur.hdr1;

    assign mixed   = old_chk ^ byte_in;
    assign new_chk = {mixed[6:0], mixed[7]};

    assign new_cnt = (old_cnt < slfm_pkg::COUNT_W'(slfm_pkg::COUNT_LIMIT))
                     ? old_cnt + slfm_pkg::COUNT_W'(1) : old_cnt;

    assign end_len = slfm_pkg::COUNT_W'(slfm_pkg::LEN_BASE) + slfm_pkg::COUNT_W'(h1[3:0]);

    assign is_ack     = (new_cnt == slfm_pkg::COUNT_W'(1)) && (h0 == slfm_pkg::BYTE_ACK);
    assign is_len_end = (new_cnt >= slfm_pkg::COUNT_W'(2)) && (h0 != slfm_pkg::BYTE_POLL0)
                        && (new_cnt == end_len);

    always_comb
    begin
        if (is_ack)
        begin
            frame_event = slfm_pkg::FE_ACK;
        end
        else if (is_len_end)
        begin
            frame_event = (new_chk == 8'h00) ? slfm_pkg::FE_GOOD : slfm_pkg::FE_BAD;
        end
        else
        begin
            frame_event = slfm_pkg::FE_NONE;
        end
    end

    assign nxt.start_pending = is_ack || is_len_end;
    assign nxt.count         = new_cnt;
    assign nxt.check         = new_chk;
    assign nxt.hdr0          = h0;
    assign nxt.hdr1          = h1;

endmodule

// ===== sv/slfm_engine.sv =====
`timescale 1ns / 1ps

module slfm_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [1:0]           kind,
    input  logic [7:0]           byte_in,
    input  logic                 master_mode,
    input  logic [7:0]           timeout_ticks,
    output slfm_pkg::result_t    result
);

    logic                           sp_reg    [2];
    logic [slfm_pkg::COUNT_W-1:0]   cnt_reg   [2];
    logic [7:0]                     chk_reg   [2];
    logic [7:0]                     hdr_reg   [4];
    slfm_pkg::phase_t               phase_reg;
    slfm_pkg::phase_t               phase_next;
    logic [slfm_pkg::CD_W-1:0]      cd_reg;
    logic [slfm_pkg::CD_W-1:0]      cd_next;
    logic                           irq_reg;
    logic                           irq_next;

    slfm_pkg::ev_kind_t             ev;
    logic                           dir;
    logic                           is_byte;
    slfm_pkg::dir_state_t           cur;
    slfm_pkg::dir_state_t           nxt;
    slfm_pkg::frame_event_t         fevent;
    logic                           send_valid;
    logic [7:0]                     send_byte;
    logic [1:0]                     phase_code;

    assign ev      = slfm_pkg::ev_kind_t'(kind);
    assign dir     = (ev == slfm_pkg::EV_DEV);
    assign is_byte = (ev == slfm_pkg::EV_CPU) || (ev == slfm_pkg::EV_DEV);

    assign cur.start_pending = sp_reg[dir];
    assign cur.count         = cnt_reg[dir];
    assign cur.check         = chk_reg[dir];
    assign cur.hdr0          = hdr_reg[{dir, 1'b0}];
    assign cur.hdr1          = hdr_reg[{dir, 1'b1}];

    slfm_deframer u_deframer
    (
        .cur         (cur),
        .byte_in     (byte_in),
        .nxt         (nxt),
        .frame_event (fevent)
    );

    always_comb
    begin
        phase_next = phase_reg;
        cd_next    = cd_reg;
        irq_next   = irq_reg;
        send_valid = 1'b0;
        send_byte  = 8'h00;
        case (ev)
            slfm_pkg::EV_TICK:
            begin
                if (cd_reg != slfm_pkg::CD_STOPPED)
                begin
                    cd_next = cd_reg - slfm_pkg::CD_W'(1);
                    if (cd_reg <= slfm_pkg::CD_W'(1))
                    begin
                        cd_next = slfm_pkg::CD_STOPPED;
                        if (master_mode)
                        begin
                            case (phase_reg)
                                slfm_pkg::PH_IDLE:
                                begin
                                    if (irq_reg)
                                    begin
                                        send_valid = 1'b1;
                                        send_byte  = slfm_pkg::BYTE_POLL0;
                                        phase_next = slfm_pkg::PH_SENT_C0;
                                        cd_next    = slfm_pkg::CD_W'(timeout_ticks);
                                    end
                                end
                                slfm_pkg::PH_SENT_C0:
                                begin
                                    send_valid = 1'b1;
                                    send_byte  = slfm_pkg::BYTE_POLL1;
                                    phase_next = slfm_pkg::PH_SENT_00;
                                    cd_next    = slfm_pkg::CD_W'(timeout_ticks);
                                end
                                slfm_pkg::PH_SENT_00:
                                begin
                                    send_valid = 1'b1;
                                    send_byte  = slfm_pkg::BYTE_POLL2;
                                    phase_next = slfm_pkg::PH_SENT_01;
                                    cd_next    = slfm_pkg::CD_W'(timeout_ticks);
                                end
                                default:
                                begin
                                    phase_next = phase_reg;
                                end
                            endcase
                        end
                    end
                end
            end
            slfm_pkg::EV_IRQ:
            begin
                irq_next = (byte_in != 8'h00);
            end
            default:
            begin
                if (dir && (fevent == slfm_pkg::FE_ACK))
                begin
                    phase_next = slfm_pkg::PH_IDLE;
                    cd_next    = slfm_pkg::CD_STOPPED;
                end
                else if (dir && (fevent != slfm_pkg::FE_NONE)
                         && (phase_reg == slfm_pkg::PH_IDLE))
                begin
                    send_valid = 1'b1;
                    send_byte  = slfm_pkg::BYTE_ACK;
                end
            end
        endcase
    end

    always_comb
    begin
        case (phase_next)
            slfm_pkg::PH_IDLE:    phase_code = slfm_pkg::PHASE_CODE_IDLE;
            slfm_pkg::PH_SENT_C0: phase_code = slfm_pkg::PHASE_CODE_C0;
            slfm_pkg::PH_SENT_00: phase_code = slfm_pkg::PHASE_CODE_00;
            slfm_pkg::PH_SENT_01: phase_code = slfm_pkg::PHASE_CODE_01;
            default:              phase_code = slfm_pkg::PHASE_CODE_IDLE;
        endcase
    end

    assign result.send_valid        = send_valid;
    assign result.send_byte         = send_byte;
    assign result.frame_event       = is_byte ? fevent : slfm_pkg::FE_NONE;
    assign result.frame_from_device = is_byte && dir;
    assign result.frame_length      = is_byte ? nxt.count[slfm_pkg::FLEN_W-1:0] : '0;
    // CPU-side frame ends in master idle ask for the next frame to be replayed.
    assign result.replay_request    = is_byte && !dir && (fevent != slfm_pkg::FE_NONE)
                                      && master_mode && (phase_reg == slfm_pkg::PH_IDLE);
    assign result.current_phase     = phase_code;
    assign result.interrupt_pending = irq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= slfm_pkg::PH_IDLE;
            cd_reg     <= slfm_pkg::CD_STOPPED;
            irq_reg    <= 1'b0;
            sp_reg[0]  <= 1'b1;
            sp_reg[1]  <= 1'b1;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            chk_reg[0] <= slfm_pkg::CHECK_INIT;
            chk_reg[1] <= slfm_pkg::CHECK_INIT;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cd_reg    <= cd_next;
            irq_reg   <= irq_next;
            if (is_byte)
            begin
                sp_reg[dir]  <= nxt.start_pending;
                cnt_reg[dir] <= nxt.count;
                chk_reg[dir] <= nxt.check;
                // Starting a frame here re-arms a start on the other side.
                if (cur.start_pending)
                begin
                    sp_reg[!dir] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && is_byte)
        begin
            hdr_reg[{dir, 1'b0}] <= nxt.hdr0;
            hdr_reg[{dir, 1'b1}] <= nxt.hdr1;
        end
    end

endmodule

// ===== sv/serial_link_frame_monitor_top.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while out_ready is high. An accepted word goes
// from the input register through the combinational deframe and timer update
// to the result register; the two registers form a two-stage pipeline.
// Reset (rst_n, asynchronous, active low) empties both stages, idles the poll
// sequence, stops the countdown and restores master_mode 0, timeout_ticks 5.

module serial_link_frame_monitor_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  event_kind,
    input  logic [7:0]  event_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        send_valid,
    output logic [7:0]  send_byte,
    output logic [1:0]  frame_event,
    output logic        frame_from_device,
    output logic [4:0]  frame_length,
    output logic        replay_request,
    output logic [1:0]  current_phase,
    output logic        interrupt_pending,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              in_vld_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        byte_reg;
    logic              out_vld_reg;
    slfm_pkg::result_t res_reg;
    slfm_pkg::result_t res_next;
    logic              advance;
    logic              master_mode_reg;
    logic [7:0]        timeout_ticks_reg;
    logic              cfg_write;

    // The staged word moves on when the result register is empty or being drained.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg <= event_kind;
            byte_reg <= event_byte;
        end
    end

    slfm_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .kind          (kind_reg),
        .byte_in       (byte_reg),
        .master_mode   (master_mode_reg),
        .timeout_ticks (timeout_ticks_reg),
        .result        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = out_vld_reg;
    assign send_valid        = res_reg.send_valid;
    assign send_byte         = res_reg.send_byte;
    assign frame_event       = res_reg.frame_event;
    assign frame_from_device = res_reg.frame_from_device;
    assign frame_length      = res_reg.frame_length;
    assign replay_request    = res_reg.replay_request;
    assign current_phase     = res_reg.current_phase;
    assign interrupt_pending = res_reg.interrupt_pending;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_mode_reg   <= 1'b0;
            timeout_ticks_reg <= slfm_pkg::TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                slfm_pkg::REG_MASTER_MODE:   master_mode_reg   <= pwdata[0];
                slfm_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[7:0];
                default:                     master_mode_reg   <= master_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            slfm_pkg::REG_MASTER_MODE:   prdata = {31'd0, master_mode_reg};
            slfm_pkg::REG_TIMEOUT_TICKS: prdata = {24'd0, timeout_ticks_reg};
            default:                     prdata = 32'd0;
        endcase
    end

`ifndef SYNTHESIS
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("result register not loaded after a staged word advanced");

    a_send_byte_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.send_valid) |->
            (res_reg.send_byte == slfm_pkg::BYTE_ACK
             || res_reg.send_byte == slfm_pkg::BYTE_POLL0
             || res_reg.send_byte == slfm_pkg::BYTE_POLL1
             || res_reg.send_byte == slfm_pkg::BYTE_POLL2))
        else $error("illegal transmit byte");

    a_poll_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.send_valid && res_reg.send_byte == slfm_pkg::BYTE_POLL0)
            |-> (res_reg.current_phase == slfm_pkg::PHASE_CODE_C0))
        else $error("poll start byte sent without entering its phase");

    a_replay_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.replay_request) |->
            (res_reg.frame_event != slfm_pkg::FE_NONE && !res_reg.frame_from_device))
        else $error("replay request without a CPU-side frame end");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import slfm_pkg::*;

    // Predicts the monitor's output word for every accepted word and
    // checks the words that come back, in order.
    class link_scoreboard;
        bit                 master_mode;
        logic [7:0]         timeout_ticks;
        logic [1:0]         phase;
        logic [CD_W-1:0]    countdown;
        bit                 irq_flag;
        bit                 start_pending [2];
        logic [COUNT_W-1:0] byte_count [2];
        logic [7:0]         running_check [2];
        logic [7:0]         header [2][2];
        result_t            pred;
        result_t            expected_q [$];
        int                 errors;

        function new();
            master_mode   = 1'b0;
            timeout_ticks = TIMEOUT_RESET;
            phase         = PHASE_CODE_IDLE;
            countdown     = CD_STOPPED;
            irq_flag      = 1'b0;
            errors        = 0;
            for (int d = 0; d < 2; d++)
            begin
                start_pending[d[0]] = 1'b1;
                byte_count[d[0]]    = '0;
                running_check[d[0]] = CHECK_INIT;
                header[d[0]][0]     = 8'h00;
                header[d[0]][1]     = 8'h00;
            end
        endfunction

        static function logic [7:0] fold_byte(logic [7:0] chk, logic [7:0] value);
            logic [7:0] x;
            x = chk ^ value;
            return {x[6:0], x[7]};
        endfunction

        function void send_poll(logic [7:0] value, logic [1:0] next_phase);
            pred.send_valid = 1'b1;
            pred.send_byte  = value;
            phase           = next_phase;
            countdown       = {1'b0, timeout_ticks};
        endfunction

        function void note_event(ev_kind_t kind, logic [7:0] value);
            bit              d;
            logic [CD_W-1:0] old;
            bit              ended;
            pred             = '0;
            pred.frame_event = FE_NONE;
            ended            = 1'b0;
            case (kind)
                EV_TICK:
                begin
                    if (countdown != CD_STOPPED)
                    begin
                        old       = countdown;
                        countdown = countdown - 1'b1;
                        if (old <= 1)
                        begin
                            countdown = CD_STOPPED;
                            if (master_mode)
                            begin
                                if (phase == PHASE_CODE_C0)
                                    send_poll(BYTE_POLL1, PHASE_CODE_00);
                                else if (phase == PHASE_CODE_00)
                                    send_poll(BYTE_POLL2, PHASE_CODE_01);
                                else if (phase == PHASE_CODE_IDLE && irq_flag)
                                    send_poll(BYTE_POLL0, PHASE_CODE_C0);
                            end
                        end
                    end
                end
                EV_IRQ:
                    irq_flag = (value != 8'h00);
                default:
                begin
                    d = (kind == EV_DEV);
                    pred.frame_from_device = (d == 1);
                    if (start_pending[d])
                    begin
                        start_pending[d]  = 1'b0;
                        start_pending[!d] = 1'b1;
                        byte_count[d]     = '0;
                        running_check[d]  = CHECK_INIT;
                    end
                    if (byte_count[d] < 2)
                        header[d][byte_count[d][0]] = value;
                    running_check[d] = fold_byte(running_check[d], value);
                    if (byte_count[d] < COUNT_LIMIT)
                        byte_count[d] = byte_count[d] + 1'b1;
                    pred.frame_length = FLEN_W'(byte_count[d]);
                    if (byte_count[d] == 1 && header[d][0] == BYTE_ACK)
                    begin
                        pred.frame_event = FE_ACK;
                        start_pending[d] = 1'b1;
                        ended            = 1'b1;
                        if (d == 1)
                        begin
                            phase     = PHASE_CODE_IDLE;
                            countdown = CD_STOPPED;
                        end
                    end
                    else if (byte_count[d] >= 2 && header[d][0] != BYTE_POLL0 &&
                             int'(byte_count[d]) ==
                             int'(LEN_BASE) + int'(header[d][1][3:0]))
                    begin
                        pred.frame_event = (running_check[d] == 8'h00) ? FE_GOOD : FE_BAD;
                        start_pending[d] = 1'b1;
                        ended            = 1'b1;
                        if (d == 1 && phase == PHASE_CODE_IDLE)
                        begin
                            pred.send_valid = 1'b1;
                            pred.send_byte  = BYTE_ACK;
                        end
                    end
                    if (ended && d == 0 && master_mode && phase == PHASE_CODE_IDLE)
                        pred.replay_request = 1'b1;
                end
            endcase
            pred.current_phase     = phase;
            pred.interrupt_pending = irq_flag;
            expected_q.push_back(pred);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result word arrived with no expectation pending");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
            compare_field("send_byte", want.send_byte, got.send_byte);
            compare_field("frame_event", 8'(want.frame_event), 8'(got.frame_event));
            compare_field("frame_from_device", 8'(want.frame_from_device),
                          8'(got.frame_from_device));
            compare_field("frame_length", 8'(want.frame_length), 8'(got.frame_length));
            compare_field("replay_request", 8'(want.replay_request),
                          8'(got.replay_request));
            compare_field("current_phase", 8'(want.current_phase),
                          8'(got.current_phase));
            compare_field("interrupt_pending", 8'(want.interrupt_pending),
                          8'(got.interrupt_pending));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  event_kind = 2'd0;
    logic [7:0]  event_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic [1:0]  frame_event;
    logic        frame_from_device;
    logic [4:0]  frame_length;
    logic        replay_request;
    logic [1:0]  current_phase;
    logic        interrupt_pending;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    link_scoreboard sb = new();
    bit             idling = 1'b1;
    int             stall_left = 0;
    int             words_sent = 0;
    result_t        seen;

    serial_link_frame_monitor_top uut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .event_kind        (event_kind),
        .event_byte        (event_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .send_valid        (send_valid),
        .send_byte         (send_byte),
        .frame_event       (frame_event),
        .frame_from_device (frame_from_device),
        .frame_length      (frame_length),
        .replay_request    (replay_request),
        .current_phase     (current_phase),
        .interrupt_pending (interrupt_pending),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 clk = ~clk;

    // Result side: check accepted words, then decide the next cycle's ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.send_valid        = send_valid;
            seen.send_byte         = send_byte;
            seen.frame_event       = frame_event_t'(frame_event);
            seen.frame_from_device = frame_from_device;
            seen.frame_length      = frame_length;
            seen.replay_request    = replay_request;
            seen.current_phase     = current_phase;
            seen.interrupt_pending = interrupt_pending;
            sb.check_result(seen);
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(1, 8) - 1;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic ev_kind_t link_side(bit dev);
        return dev ? EV_DEV : EV_CPU;
    endfunction

    // A first byte that neither acknowledges nor disables the length end.
    function automatic logic [7:0] plain_first();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == BYTE_ACK || b == BYTE_POLL0);
        return b;
    endfunction

    task automatic push_event(ev_kind_t kind, logic [7:0] value);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        event_kind <= kind;
        event_byte <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_event(kind, value);
        if (kind != EV_TICK)
            words_sent++;
    endtask

    // Sends a frame of 3 + nibble bytes, or only its first keep bytes.
    task automatic send_frame(bit dev, logic [7:0] first, logic [3:0] nibble, bit good,
                              int keep = 0);
        logic [7:0] chk;
        logic [7:0] b;
        int         total;
        total = 3 + nibble;
        if (keep == 0 || keep > total)
            keep = total;
        chk = CHECK_INIT;
        for (int i = 0; i < keep; i++)
        begin
            if (i == 0)
                b = first;
            else if (i == 1)
                b = {4'($urandom_range(0, 15)), nibble};
            else if (i == total - 1)
                b = good ? chk : chk ^ 8'($urandom_range(1, 255));
            else
                b = 8'($urandom);
            chk = link_scoreboard::fold_byte(chk, b);
            push_event(link_side(dev), b);
        end
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic write_settings(bit master, logic [7:0] ticks);
        apb_write({REG_MASTER_MODE, 2'b00}, {31'd0, master});
        sb.master_mode = master;
        apb_write({REG_TIMEOUT_TICKS, 2'b00}, {24'd0, ticks});
        sb.timeout_ticks = ticks;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(int words);
        int stop_at;
        int pick;
        bit dev;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            dev  = 1'($urandom_range(0, 1));
            if (pick < 45)
                send_frame(dev, plain_first(), 4'($urandom), $urandom_range(0, 3) != 0);
            else if (pick < 55)
                push_event(link_side(dev), BYTE_ACK);
            else if (pick < 70)
                repeat ($urandom_range(1, 4)) push_event(EV_TICK, 8'($urandom));
            else if (pick < 78)
                push_event(EV_IRQ, $urandom_range(0, 1) ? 8'($urandom) : 8'h00);
            else if (pick < 86)
            begin
                // A frame led by the poll byte never ends by length, so the count
                // can run into saturation until the other side starts a frame.
                push_event(link_side(dev), BYTE_POLL0);
                repeat ($urandom_range(1, 40)) push_event(link_side(dev), 8'($urandom));
                send_frame(!dev, plain_first(), 4'($urandom), 1'b1);
            end
            else if (pick < 94)
            begin
                send_frame(dev, plain_first(), 4'($urandom_range(1, 15)), 1'b1,
                           $urandom_range(1, 3));
                send_frame(!dev, plain_first(), 4'($urandom), 1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 5)) push_event(link_side(dev), 8'($urandom));
                push_event(link_side(!dev), BYTE_ACK);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: sniffer mode, so a CPU acknowledge asks for no replay.
        push_event(EV_TICK, 8'h00);
        push_event(EV_CPU, BYTE_ACK);
        wait_drained();

        write_settings(1'b1, 8'd1);
        push_event(EV_IRQ, 8'hFF);
        push_event(EV_TICK, 8'hFF);
        push_event(EV_IRQ, 8'h00);
        push_event(EV_CPU, BYTE_ACK);
        push_event(EV_DEV, BYTE_ACK);
        send_frame(1'b1, 8'h00, 4'h0, 1'b1);
        send_frame(1'b0, 8'hFF, 4'h0, 1'b1);
        send_frame(1'b1, 8'h7E, 4'h0, 1'b0);
        push_event(EV_DEV, BYTE_POLL0);
        push_event(EV_DEV, 8'h0F);
        push_event(EV_DEV, 8'hFF);
        push_event(EV_DEV, 8'h00);
        push_event(EV_CPU, BYTE_ACK);
        run_random(200);

        wait_drained();
        write_settings(1'b0, 8'd255);
        run_random(200);

        wait_drained();
        write_settings(1'b1, 8'($urandom_range(2, 254)));
        run_random(200);

        wait_drained();
        write_settings(1'b1, 8'd255);
        run_random(200);

        wait_drained();
        write_settings(1'b0, TIMEOUT_RESET);
        idling = 1'b0;
        run_random(200);

        wait_drained();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/slfm_pkg.sv
sv/slfm_deframer.sv
sv/slfm_engine.sv
sv/serial_link_frame_monitor_top.sv
tb/sv/tb_top.sv
